// ===== design/lds_pkg.sv =====
`default_nettype none
package lds_pkg;

    // vector and unit-vector formats
    localparam int VEC_W      = 17;     // Q9.8 signed, covers light minus surface
    localparam int UNIT_W     = 16;     // Q1.14 signed
    localparam int SQ_W       = 2 * VEC_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int REM_W      = SUM_W + 1;

    // divider: floor(m^2 * 2^28 / sum), quotient never above 2^28
    localparam int QUO_W      = 29;
    localparam int DIV_STEPS  = QUO_W;

    // square root of the quotient, one result bit per stage
    localparam int SQRT_STEPS = (QUO_W + 1) / 2;
    localparam int RES_W      = QUO_W + 1;
    localparam int ROOT_W     = SQRT_STEPS;

    // abs/square, sum, divider, root, sign
    localparam int NORM_LAT   = 2 + DIV_STEPS + SQRT_STEPS + 1;

    // per-light term
    localparam int SHADE_LAT  = 4;
    localparam int CI_W       = 16;
    localparam int CIB_W      = 26;
    localparam int DOTS_W     = 2 * UNIT_W + 2;
    localparam int DOT_W      = 30;
    localparam int NUM_W      = CIB_W + DOT_W;
    localparam int NUM_SHIFT  = 34;
    localparam int QX_W       = NUM_W - NUM_SHIFT;
    localparam int RECIP_W    = 23;
    localparam int PR_W       = QX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_255 = 23'd4210753;  // ceil(2^30 / 255)
    localparam int RECIP_SHIFT = 30;
    localparam int TERM_W     = 15;

    typedef logic signed [VEC_W-1:0]  vcomp_t;
    typedef vcomp_t [2:0]             vec_t;     // [2] x, [1] y, [0] z
    typedef logic signed [UNIT_W-1:0] ucomp_t;
    typedef ucomp_t [2:0]             uvec_t;
    typedef logic [2:0][7:0]          rgb_t;     // [2] red, [1] green, [0] blue
    typedef logic [TERM_W-1:0]        term_t;
    typedef term_t [2:0]              termv_t;

    typedef struct packed {
        logic       en;
        logic [7:0] inten;   // Q3.5
        rgb_t       color;
    } light_ctl_t;

endpackage
`default_nettype wire

// ===== design/lds_norm.sv =====
`default_nettype none
module lds_norm (
    input  logic           clk,
    input  lds_pkg::vec_t  vin,
    output lds_pkg::uvec_t uout
);
    import lds_pkg::*;

    logic [VEC_W-1:0] mag [3];
    logic [SQ_W-1:0]  sq_reg [3];
    logic [2:0]       neg_a_reg;
    logic [SUM_W-1:0] sum;
    logic [REM_W-1:0] rem_reg [DIV_STEPS][3];
    logic [SUM_W-1:0] d_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [1:DIV_STEPS][3];
    logic [2:0]       neg_reg [DIV_STEPS+1];
    logic             zero_reg [DIV_STEPS+1];
    logic [QUO_W-1:0] x_in [3];
    logic [QUO_W-1:0] sx_reg [SQRT_STEPS-1][3];
    logic [RES_W-1:0] sr_reg [SQRT_STEPS][3];
    logic [2:0]       sn_reg [SQRT_STEPS];
    uvec_t            u_reg;

    // magnitude and square
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mag[c] = vin[c][VEC_W-1] ? (~vin[c] + 1'b1) : vin[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c]    <= SQ_W'(mag[c]) * SQ_W'(mag[c]);
            neg_a_reg[c] <= vin[c][VEC_W-1];
        end
    end

    // squared length
    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            rem_reg[0][c] <= REM_W'(sq_reg[c]);
        end
        d_reg[0]    <= sum;
        neg_reg[0]  <= neg_a_reg;
        zero_reg[0] <= (sum == '0);
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [REM_W-1:0] sh [3];
        logic [QUO_W-1:0] qp [3];
        logic [2:0]       qb;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sh[c] = rem_reg[k][c];
                    qp[c] = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sh[c] = {rem_reg[k][c][REM_W-2:0], 1'b0};
                    qp[c] = quo_reg[k][c];
                end
            end
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                qb[c] = (sh[c] >= REM_W'(d_reg[k]));
            end
        end

        always_ff @(posedge clk)
        begin
            for (int c = 0; c < 3; c++)
            begin
                quo_reg[k+1][c] <= {qp[c][QUO_W-2:0], qb[c]};
            end
            neg_reg[k+1]  <= neg_reg[k];
            zero_reg[k+1] <= zero_reg[k];
        end

        if (k < DIV_STEPS - 1)
        begin : g_carry
            logic [REM_W-1:0] rn [3];

            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rn[c] = qb[c] ? (sh[c] - REM_W'(d_reg[k])) : sh[c];
                end
            end

            always_ff @(posedge clk)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_reg[k+1][c] <= rn[c];
                end
                d_reg[k+1] <= d_reg[k];
            end
        end
    end

    // zero vector normalizes to zero
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            x_in[c] = zero_reg[DIV_STEPS] ? '0 : quo_reg[DIV_STEPS][c];
        end
    end

    // digit-by-digit integer square root
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [QUO_W-1:0] xp [3];
        logic [RES_W-1:0] rp [3];
        logic [RES_W-1:0] t [3];
        logic [2:0]       np;
        logic [2:0]       ge;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    xp[c] = x_in[c];
                    rp[c] = '0;
                end
                np = neg_reg[DIV_STEPS];
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    xp[c] = sx_reg[j-1][c];
                    rp[c] = sr_reg[j-1][c];
                end
                np = sn_reg[j-1];
            end
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                t[c]  = rp[c] + BIT;
                ge[c] = (RES_W'(xp[c]) >= t[c]);
            end
        end

        always_ff @(posedge clk)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sr_reg[j][c] <= ge[c] ? ((rp[c] >> 1) + BIT) : (rp[c] >> 1);
            end
            sn_reg[j] <= np;
        end

        if (j < SQRT_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sx_reg[j][c] <= ge[c] ? (xp[c] - QUO_W'(t[c])) : xp[c];
                end
            end
        end
    end

    // restore sign
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            u_reg[c] <= sn_reg[SQRT_STEPS-1][c]
                      ? -UNIT_W'(sr_reg[SQRT_STEPS-1][c][ROOT_W-1:0])
                      :  UNIT_W'(sr_reg[SQRT_STEPS-1][c][ROOT_W-1:0]);
        end
    end

    assign uout = u_reg;

endmodule
`default_nettype wire

// ===== design/lds_shade.sv =====
`default_nettype none
module lds_shade (
    input  logic                clk,
    input  lds_pkg::uvec_t      nu,
    input  lds_pkg::uvec_t      lu,
    input  lds_pkg::rgb_t       base,
    input  lds_pkg::light_ctl_t ctl,
    output lds_pkg::termv_t     term
);
    import lds_pkg::*;

    logic signed [2*UNIT_W-1:0] prod_reg [3];
    logic [CI_W-1:0]            ci_reg [3];
    rgb_t                       base_reg;
    logic [CIB_W-1:0]           cb [3];
    logic signed [DOTS_W-1:0]   dot_reg;
    logic [CIB_W-1:0]           cib_reg [3];
    logic [DOT_W-1:0]           dclamp;
    logic [NUM_W-1:0]           num [3];
    logic [QX_W-1:0]            qx_reg [3];
    logic [PR_W-1:0]            pr [3];
    termv_t                     term_reg;

    // S1: component products, color x intensity
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= $signed(nu[c]) * $signed(lu[c]);
            ci_reg[c]   <= CI_W'(ctl.color[c]) * CI_W'(ctl.inten);
        end
        base_reg <= base;
    end

    // S2: dot product, x base x 3
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cb[c] = CIB_W'(ci_reg[c]) * CIB_W'(base_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            cib_reg[c] <= cb[c] + (cb[c] << 1);
        end
        dot_reg <= DOTS_W'(prod_reg[0]) + DOTS_W'(prod_reg[1]) + DOTS_W'(prod_reg[2]);
    end

    // S3: clamp and scale, drop the low 34 bits
    assign dclamp = (dot_reg > 0) ? dot_reg[DOT_W-1:0] : '0;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            num[c] = NUM_W'(cib_reg[c]) * NUM_W'(dclamp);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            qx_reg[c] <= ctl.en ? num[c][NUM_W-1:NUM_SHIFT] : '0;
        end
    end

    // S4: divide by 255 through the reciprocal, exact over the range of qx
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pr[c] = PR_W'(qx_reg[c]) * PR_W'(RECIP_255);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            term_reg[c] <= pr[c][RECIP_SHIFT +: TERM_W];
        end
    end

    assign term = term_reg;

endmodule
`default_nettype wire

// ===== design/lambert_diffuse_shader_top.sv =====
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+------------------------------------------
// input     | start (transfer when !busy)   | base_red/green/blue, normal_x/y/z,
//           |                               | surface_x/y/z
// result    | done (one-cycle strobe)       | lit_red, lit_green, lit_blue
// config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item per cycle. busy is always low: the pipeline takes a transfer on every edge.
// The data for an item passes from its accepting edge through the normalizer (29-stage
// restoring divider, then a 15-stage square root), four term stages and the output
// register, and the done strobe comes with the result.
// rst_n clears the valid chain, done and the light registers; data stages are not reset.
// No stalls: results leave on the strobe and the receiver cannot hold them off.
`default_nettype none
module lambert_diffuse_shader_top #(
    parameter int MAX_LIGHTS = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [7:0]                     base_red,
    input  logic [7:0]                     base_green,
    input  logic [7:0]                     base_blue,
    input  logic signed [15:0]             normal_x,
    input  logic signed [15:0]             normal_y,
    input  logic signed [15:0]             normal_z,
    input  logic signed [15:0]             surface_x,
    input  logic signed [15:0]             surface_y,
    input  logic signed [15:0]             surface_z,
    output logic                           done,
    output logic [7:0]                     lit_red,
    output logic [7:0]                     lit_green,
    output logic [7:0]                     lit_blue,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [56:0]                    cfg_data
);
    import lds_pkg::*;

    // register map
    localparam logic [2:0] CFG_LIGHT_COUNT     = 3'd0;
    localparam logic [2:0] CFG_LIGHT0_GEOMETRY = 3'd1;
    localparam logic [2:0] CFG_LIGHT0_COLOR    = 3'd2;
    localparam int         CFG_LIGHT_STRIDE    = 2;

    // ambient = floor(base * 3 / 10) = (base * 615) >> 11 for 8-bit base
    localparam int              AMB_W      = 7;
    localparam int              AMB_PROD_W = 18;
    localparam logic [9:0]      AMB_RECIP  = 10'd615;
    localparam int              AMB_SHIFT  = 11;
    localparam logic [7:0]      AMB_MAX    = 8'((255 * 615) >> 11);

    localparam int TOT    = NORM_LAT + SHADE_LAT;
    localparam int LAT    = TOT + 1;
    localparam int SUMC_W = TERM_W + 2;

    // ---------------- configuration registers ----------------
    logic [1:0]  light_count_reg;
    logic [56:0] geo_reg [MAX_LIGHTS];
    logic [23:0] col_reg [MAX_LIGHTS];
    logic [1:0]  count_sat;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_count_reg <= '0;
            for (int i = 0; i < MAX_LIGHTS; i++)
            begin
                geo_reg[i] <= '0;
                col_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_LIGHT_COUNT)
            begin
                light_count_reg <= cfg_data[1:0];
            end
            for (int i = 0; i < MAX_LIGHTS; i++)
            begin
                if (cfg_index == CFG_LIGHT0_GEOMETRY + 3'(CFG_LIGHT_STRIDE * i))
                begin
                    geo_reg[i] <= cfg_data;
                end
                if (cfg_index == CFG_LIGHT0_COLOR + 3'(CFG_LIGHT_STRIDE * i))
                begin
                    col_reg[i] <= cfg_data[23:0];
                end
            end
        end
    end

    // counts above the light array clamp to it
    assign count_sat = (light_count_reg > 2'(MAX_LIGHTS)) ? 2'(MAX_LIGHTS) : light_count_reg;

    // Config must only change with the pipe empty; the block does not enforce it. Later stages read it directly.
    light_ctl_t ctl [MAX_LIGHTS];

    always_comb
    begin
        for (int i = 0; i < MAX_LIGHTS; i++)
        begin
            ctl[i].en    = (2'(i) < count_sat);
            ctl[i].inten = geo_reg[i][55:48];
            ctl[i].color = col_reg[i];
        end
    end

    // ---------------- input register ----------------
    rgb_t                 base_in;
    vec_t                 nvec_in;
    vec_t                 lvec_in [MAX_LIGHTS];
    logic                 v0_reg;
    rgb_t                 base0_reg;
    logic [2:0][AMB_W-1:0] amb0_reg;
    vec_t                 nvec0_reg;
    vec_t                 lvec0_reg [MAX_LIGHTS];
    logic signed [15:0]   surf [3];
    logic signed [15:0]   lpos;

    assign base_in = {base_red, base_green, base_blue};
    assign surf[2] = surface_x;
    assign surf[1] = surface_y;
    assign surf[0] = surface_z;

    always_comb
    begin
        nvec_in[2] = VEC_W'(normal_x);
        nvec_in[1] = VEC_W'(normal_y);
        nvec_in[0] = VEC_W'(normal_z);
        lpos       = '0;
        for (int i = 0; i < MAX_LIGHTS; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lpos = $signed(geo_reg[i][16*c +: 16]);
                // point light: vector from the surface to the light
                lvec_in[i][c] = geo_reg[i][56] ? (VEC_W'(lpos) - VEC_W'(surf[c]))
                                               :  VEC_W'(lpos);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        base0_reg <= base_in;
        nvec0_reg <= nvec_in;
        for (int c = 0; c < 3; c++)
        begin
            amb0_reg[c] <= AMB_W'((AMB_PROD_W'(base_in[c]) * AMB_PROD_W'(AMB_RECIP))
                                  >> AMB_SHIFT);
        end
        for (int i = 0; i < MAX_LIGHTS; i++)
        begin
            lvec0_reg[i] <= lvec_in[i];
        end
    end

    // ---------------- normalize and shade ----------------
    uvec_t  nu;
    uvec_t  lu [MAX_LIGHTS];
    termv_t term [MAX_LIGHTS];

    // sideband delay lines: valid and ambient run the full depth, base to the shader
    logic                  vpipe_reg [TOT];
    logic [2:0][AMB_W-1:0] apipe_reg [TOT];
    rgb_t                  bpipe_reg [NORM_LAT];

    lds_norm u_nnorm (
        .clk  (clk),
        .vin  (nvec0_reg),
        .uout (nu)
    );

    for (genvar i = 0; i < MAX_LIGHTS; i++)
    begin : g_light
        lds_norm u_lnorm (
            .clk  (clk),
            .vin  (lvec0_reg[i]),
            .uout (lu[i])
        );

        lds_shade u_shade (
            .clk  (clk),
            .nu   (nu),
            .lu   (lu[i]),
            .base (bpipe_reg[NORM_LAT-1]),
            .ctl  (ctl[i]),
            .term (term[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOT; k++)
            begin
                vpipe_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vpipe_reg[0] <= v0_reg;
            for (int k = 1; k < TOT; k++)
            begin
                vpipe_reg[k] <= vpipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        apipe_reg[0] <= amb0_reg;
        bpipe_reg[0] <= base0_reg;
        for (int k = 1; k < TOT; k++)
        begin
            apipe_reg[k] <= apipe_reg[k-1];
        end
        for (int k = 1; k < NORM_LAT; k++)
        begin
            bpipe_reg[k] <= bpipe_reg[k-1];
        end
    end

    // ---------------- accumulate, saturate, output ----------------
    logic [SUMC_W-1:0] acc [3];
    logic              done_reg;
    rgb_t              lit_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = SUMC_W'(apipe_reg[TOT-1][c]);
            for (int i = 0; i < MAX_LIGHTS; i++)
            begin
                acc[c] = acc[c] + SUMC_W'(term[i][c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vpipe_reg[TOT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            lit_reg[c] <= (acc[c] > SUMC_W'(8'hFF)) ? 8'hFF : acc[c][7:0];
        end
    end

    assign done      = done_reg;
    assign lit_red   = lit_reg[2];
    assign lit_green = lit_reg[1];
    assign lit_blue  = lit_reg[0];

    // ---------------- assertions ----------------
    // every strobe traces back to a transfer at the fixed depth
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT + 1))
        else $error("done without a matching input transfer");

    // a zero normal gets ambient only, checked as no channel above the ambient maximum
    a_zero_normal_ambient: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && normal_x == 16'sd0 && normal_y == 16'sd0
                       && normal_z == 16'sd0, LAT + 1))
        |-> (lit_red <= AMB_MAX && lit_green <= AMB_MAX && lit_blue <= AMB_MAX))
        else $error("zero normal produced a diffuse term");

endmodule
`default_nettype wire
